>>> src/esd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_pkg
// Types, character codes and helpers for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

   // decoder mode, one-hot
   typedef enum logic [4:0] {
      MODE_NORMAL = 5'b00001,
      MODE_ESCAPE = 5'b00010,
      MODE_HEX    = 5'b00100,
      MODE_OCTAL  = 5'b01000,
      MODE_DROP   = 5'b10000
   } mode_type;

   // one result entry
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       out_error;
   } result_type;

   // hex digit lookup result
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_QUOTE  = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_7      = 8'h37;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_UA     = 8'h41;
   localparam logic [7:0] CHAR_UF     = 8'h46;

   localparam logic [7:0] CTRL_BEL = 8'h07;
   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_CR  = 8'h0D;
   localparam logic [7:0] CTRL_TAB = 8'h09;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   function automatic digit_type hex_value(input logic [7:0] c);
      digit_type d;
      d = '{ok: 1'b0, value: 4'd0};
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d.ok    = 1'b1;
         d.value = c[3:0];
      end else if (c >= CHAR_A && c <= CHAR_F) begin
         d.ok    = 1'b1;
         d.value = c[3:0] + 4'd9;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d.ok    = 1'b1;
         d.value = c[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

>>> src/esd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_req_if / esd_rsp_if
// Valid/ready channels for encoded input bytes and decoded results.
// ----------------------------------------------------------------------------
interface esd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       out_error;

   modport source (output valid, output out_byte, output out_last, output out_error,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input out_error,
                   output ready);
endinterface
`default_nettype wire

>>> src/escape_sequence_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top
// C-style escape decoder for a byte stream, one label at a time.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                          | transfer when
//  req_ch   | in  | in_byte[7:0], in_last            | valid && ready
//  rsp_ch   | out | out_byte[7:0], out_last, out_err | valid && ready
//
//  One input byte is decoded per cycle while req ready is high; its zero, one
//  or two results go into a four-entry result queue in the same cycle. The
//  queue drains one result per cycle while rsp ready is high; an unknown escape
//  gives two results for one byte. req ready is high while the queue has room
//  for two results. Reset (synchronous) empties the queue and returns to normal
//  text mode; a stalled rsp side fills the queue and then holds off input.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_top
   import esd_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   esd_req_if.sink      req_ch,
   esd_rsp_if.source    rsp_ch
);

   // decoder state
   mode_type   mode_ff,  mode_in;
   logic [7:0] accum_ff, accum_in;
   logic [1:0] left_ff,  left_in;

   // result queue
   result_type           queue_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;

   // per-byte decode outputs
   logic [1:0]  push_n;
   result_type  res0, res1;
   logic        fire, pop;
   logic [7:0]  c;
   logic        last;
   digit_type   hex_d;
   logic        is_octal;
   logic [1:0]  left_dec;
   logic [7:0]  simple_val;
   logic        simple_hit;
   logic [PTR_W-1:0] wr_ptr_nx;

   assign fire = req_ch.valid && req_ch.ready;
   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign c    = req_ch.in_byte;
   assign last = req_ch.in_last;

   // room for the worst case of two results
   assign req_ch.ready = (count_ff <= CNT_W'(FIFO_DEPTH - 2));

   assign hex_d    = hex_value(c);
   assign is_octal = (c >= CHAR_0) && (c <= CHAR_7);
   assign left_dec = left_ff - 2'd1;

   // single-character escapes
   always_comb begin
      simple_hit = 1'b1;
      case (c)
         CHAR_A:      simple_val = CTRL_BEL;
         CHAR_B:      simple_val = CTRL_BS;
         CHAR_F:      simple_val = CTRL_FF;
         CHAR_N:      simple_val = CTRL_LF;
         CHAR_R:      simple_val = CTRL_CR;
         CHAR_T:      simple_val = CTRL_TAB;
         CHAR_BSLASH: simple_val = CHAR_BSLASH;
         CHAR_QUOTE:  simple_val = CHAR_QUOTE;
         CHAR_DQUOTE: simple_val = CHAR_DQUOTE;
         default: begin
            simple_val = 8'd0;
            simple_hit = 1'b0;
         end
      endcase
   end

   // decode of one byte: next state and up to two results
   always_comb begin
      logic fail;
      fail     = 1'b0;
      mode_in  = mode_ff;
      accum_in = accum_ff;
      left_in  = left_ff;
      push_n   = 2'd0;
      res0     = '{out_byte: c, out_last: last, out_error: 1'b0};
      res1     = '{out_byte: c, out_last: last, out_error: 1'b0};

      case (mode_ff)
         MODE_DROP: begin
            if (last) mode_in = MODE_NORMAL;
         end
         MODE_ESCAPE: begin
            if (simple_hit) begin
               res0.out_byte = simple_val;
               push_n        = 2'd1;
               mode_in       = MODE_NORMAL;
            end else if (c == CHAR_X) begin
               if (last) fail = 1'b1;
               else begin
                  mode_in  = MODE_HEX;
                  accum_in = 8'd0;
                  left_in  = 2'd2;
               end
            end else if (is_octal) begin
               if (last) fail = 1'b1;
               else begin
                  mode_in  = MODE_OCTAL;
                  accum_in = {5'd0, c[2:0]};
                  left_in  = 2'd2;
               end
            end else begin
               // unknown escape: backslash, then the byte as is
               res0.out_byte = CHAR_BSLASH;
               res0.out_last = 1'b0;
               push_n        = 2'd2;
               mode_in       = MODE_NORMAL;
            end
         end
         MODE_HEX: begin
            if (!hex_d.ok) fail = 1'b1;
            else begin
               accum_in = {accum_ff[3:0], hex_d.value};
               left_in  = left_dec;
               if (left_dec == 2'd0) begin
                  res0.out_byte = accum_in;
                  push_n        = 2'd1;
                  mode_in       = MODE_NORMAL;
                  accum_in      = 8'd0;
               end else if (last) fail = 1'b1;
            end
         end
         MODE_OCTAL: begin
            if (!is_octal) fail = 1'b1;
            else begin
               accum_in = {accum_ff[4:0], c[2:0]};
               left_in  = left_dec;
               if (left_dec == 2'd0) begin
                  res0.out_byte = accum_in;
                  push_n        = 2'd1;
                  mode_in       = MODE_NORMAL;
                  accum_in      = 8'd0;
               end else if (last) fail = 1'b1;
            end
         end
         default: begin
            // normal text, also any stray code
            if (c == CHAR_BSLASH) begin
               if (last) fail = 1'b1;
               else mode_in = MODE_ESCAPE;
            end else begin
               push_n  = 2'd1;
               mode_in = MODE_NORMAL;
            end
         end
      endcase

      if (fail) begin
         res0     = '{out_byte: 8'd0, out_last: 1'b1, out_error: 1'b1};
         push_n   = 2'd1;
         mode_in  = last ? MODE_NORMAL : MODE_DROP;
         accum_in = 8'd0;
         left_in  = 2'd0;
      end
   end

   // queue pointers
   assign wr_ptr_nx = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (fire) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
         count_in  = count_in + CNT_W'(push_n);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         accum_ff  <= 8'd0;
         left_ff   <= 2'd0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (fire) begin
            mode_ff  <= mode_in;
            accum_ff <= accum_in;
            left_ff  <= left_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (fire && push_n != 2'd0) queue_ff[wr_ptr_ff] <= res0;
      if (fire && push_n == 2'd2) queue_ff[wr_ptr_nx] <= res1;
   end

   assign rsp_ch.valid     = (count_ff != '0);
   assign rsp_ch.out_byte  = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_ch.out_last  = queue_ff[rd_ptr_ff].out_last;
   assign rsp_ch.out_error = queue_ff[rd_ptr_ff].out_error;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_error |-> rsp_ch.out_last && rsp_ch.out_byte == 8'd0)
      else $error("error result not last or not zero");

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      fire && mode_ff == MODE_DROP |-> push_n == 2'd0)
      else $error("result produced while dropping");

   a_hex_left: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HEX || mode_ff == MODE_OCTAL |-> left_ff != 2'd0)
      else $error("numeric escape with no digits left");
`endif

endmodule
`default_nettype wire
